FILE: hdl/lphi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lphi_pkg: shared types and constants of the linear-probe hash index
// Slot count, function codes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package lphi_pkg;

  localparam int SLOTS      = 1024;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = 11;
  localparam int LOAD_NUM   = 7;
  localparam int LOAD_DEN   = 10;
  // Used count at which an insert is refused, since one more entry would
  // push the load past the limit.
  localparam int LOAD_LIMIT = (SLOTS * LOAD_NUM) / LOAD_DEN;

  typedef enum logic [1:0] {
    FUNC_FIND   = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_ERASE  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FREAD,
    ST_FCHECK,
    ST_EREAD,
    ST_ECHECK,
    ST_SREAD,
    ST_SCHECK,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: hdl/linear_probe_hash_index.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_probe_hash_index: open-addressing index with backward-shift erase
// Linear-probing table of lphi_pkg::SLOTS slots held in one block memory.
// ----------------------------------------------------------------------------
// One word is taken at a time. A small sequencer walks the probe sequence,
// visiting one slot at a time (read, then compare the registered data);
// an erase then inspects each later cluster member in turn during the
// backward shift. After reset, and on a clear word, a clearing pass writes
// every slot empty, one slot a cycle; no input word is taken meanwhile.
// The result is held in an output register until taken, and in_stall is
// high from acceptance until the result is delivered.
module linear_probe_hash_index (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [63:0] in_key_hash,
  input  wire logic [63:0] in_key_word,
  input  wire logic [15:0] in_entry_handle,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_found,
  output logic [15:0]      out_handle_out,
  output logic [1:0]       out_status,
  output logic [10:0]      out_occupied
);

  localparam int IW = lphi_pkg::IDX_W;
  localparam int CW = lphi_pkg::CNT_W;

  // Slot storage: one memory, one read and one write port.
  logic [143:0] mem [lphi_pkg::SLOTS];
  logic [143:0] rd_r;
  logic [IW-1:0] ra;
  logic          we;
  logic [IW-1:0] wa;
  logic [143:0]  wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_r <= mem[ra];
  end

  wire [63:0] rd_hash   = rd_r[143:80];
  wire [63:0] rd_key    = rd_r[79:16];
  wire [15:0] rd_handle = rd_r[15:0];

  lphi_pkg::state_t state_r, state_nxt;
  logic [1:0]  func_r;
  logic [63:0] hash_r, key_r;
  logic [15:0] eh_r;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [IW:0]   n_r, n_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          found_r, found_nxt;
  logic [15:0]   hout_r, hout_nxt;
  logic [1:0]    stat_r, stat_nxt;

  wire accept = in_valid && !in_stall;
  wire [IW-1:0] i_inc = i_r + IW'(1);
  wire [IW-1:0] j_inc = j_r + IW'(1);
  wire          n_end = (n_r == (IW+1)'(lphi_pkg::SLOTS - 1));
  wire [IW-1:0] home_j = rd_hash[IW-1:0];
  // A member stays when its home lies cyclically in (i, j].
  wire stays = (i_r <= j_r) ? (home_j > i_r && home_j <= j_r)
                            : (home_j > i_r || home_j <= j_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lphi_pkg::ST_CLEAR:  if (n_end) state_nxt = lphi_pkg::ST_DONE;
      lphi_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (lphi_pkg::func_t'(in_func))
            lphi_pkg::FUNC_CLEAR: state_nxt = lphi_pkg::ST_CLEAR;
            lphi_pkg::FUNC_FIND:  state_nxt = lphi_pkg::ST_FREAD;
            lphi_pkg::FUNC_INSERT: begin
              if (in_entry_handle == 16'd0 ||
                  cnt_r >= CW'(lphi_pkg::LOAD_LIMIT)) begin
                state_nxt = lphi_pkg::ST_DONE;
              end else begin
                state_nxt = lphi_pkg::ST_FREAD;
              end
            end
            lphi_pkg::FUNC_ERASE: begin
              if (in_entry_handle == 16'd0) state_nxt = lphi_pkg::ST_DONE;
              else state_nxt = lphi_pkg::ST_EREAD;
            end
            default: state_nxt = lphi_pkg::ST_DONE;
          endcase
        end
      end
      lphi_pkg::ST_FREAD:  state_nxt = lphi_pkg::ST_FCHECK;
      lphi_pkg::ST_FCHECK: begin
        if (rd_handle == 16'd0 || n_end) state_nxt = lphi_pkg::ST_DONE;
        else if (func_r == lphi_pkg::FUNC_FIND && rd_hash == hash_r &&
                 rd_key == key_r) state_nxt = lphi_pkg::ST_DONE;
        else state_nxt = lphi_pkg::ST_FREAD;
      end
      lphi_pkg::ST_EREAD:  state_nxt = lphi_pkg::ST_ECHECK;
      lphi_pkg::ST_ECHECK: begin
        if (rd_handle == eh_r) state_nxt = lphi_pkg::ST_SREAD;
        else if (rd_handle == 16'd0 || n_end) state_nxt = lphi_pkg::ST_DONE;
        else state_nxt = lphi_pkg::ST_EREAD;
      end
      lphi_pkg::ST_SREAD:  state_nxt = lphi_pkg::ST_SCHECK;
      lphi_pkg::ST_SCHECK: begin
        if (rd_handle == 16'd0 || n_end) state_nxt = lphi_pkg::ST_DONE;
        else state_nxt = lphi_pkg::ST_SREAD;
      end
      lphi_pkg::ST_DONE:   if (!out_stall) state_nxt = lphi_pkg::ST_IDLE;
      default:             state_nxt = lphi_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    i_nxt = i_r; j_nxt = j_r; n_nxt = n_r; cnt_nxt = cnt_r;
    found_nxt = found_r; hout_nxt = hout_r; stat_nxt = stat_r;
    ra = i_r; we = 1'b0; wa = i_r; wd = '0;
    unique case (state_r)
      lphi_pkg::ST_CLEAR: begin
        we = 1'b1; wa = n_r[IW-1:0];
        n_nxt = n_r + (IW+1)'(1);
        cnt_nxt = '0;
      end
      lphi_pkg::ST_IDLE: begin
        if (accept) begin
          i_nxt = in_key_hash[IW-1:0];
          n_nxt = '0;
          found_nxt = 1'b0; hout_nxt = '0; stat_nxt = lphi_pkg::STAT_OK;
          if (in_func == lphi_pkg::FUNC_INSERT && in_entry_handle != 16'd0 &&
              cnt_r >= CW'(lphi_pkg::LOAD_LIMIT)) stat_nxt = lphi_pkg::STAT_FULL;
          if (in_func == lphi_pkg::FUNC_ERASE && in_entry_handle == 16'd0)
            stat_nxt = lphi_pkg::STAT_ABSENT;
        end
      end
      lphi_pkg::ST_FREAD, lphi_pkg::ST_EREAD: ra = i_r;
      lphi_pkg::ST_FCHECK: begin
        if (rd_handle == 16'd0) begin
          if (func_r == lphi_pkg::FUNC_INSERT) begin
            we = 1'b1; wa = i_r; wd = {hash_r, key_r, eh_r};
            cnt_nxt = cnt_r + CW'(1);
          end
        end else if (func_r == lphi_pkg::FUNC_FIND && rd_hash == hash_r &&
                     rd_key == key_r) begin
          found_nxt = 1'b1; hout_nxt = rd_handle;
        end else begin
          if (n_end && func_r == lphi_pkg::FUNC_INSERT)
            stat_nxt = lphi_pkg::STAT_FULL;
          i_nxt = i_inc; n_nxt = n_r + (IW+1)'(1);
        end
      end
      lphi_pkg::ST_ECHECK: begin
        if (rd_handle == eh_r) begin
          found_nxt = 1'b1; j_nxt = i_inc; n_nxt = '0;
        end else if (rd_handle == 16'd0 || n_end) begin
          stat_nxt = lphi_pkg::STAT_ABSENT;
        end else begin
          i_nxt = i_inc; n_nxt = n_r + (IW+1)'(1);
        end
      end
      lphi_pkg::ST_SREAD: ra = j_r;
      lphi_pkg::ST_SCHECK: begin
        if (rd_handle == 16'd0 || n_end) begin
          we = 1'b1; wa = i_r; wd = '0;
          if (cnt_r != '0) cnt_nxt = cnt_r - CW'(1);
        end else begin
          if (!stays) begin
            we = 1'b1; wa = i_r; wd = rd_r; i_nxt = j_r;
          end
          j_nxt = j_inc; n_nxt = n_r + (IW+1)'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lphi_pkg::ST_CLEAR;
      n_r     <= '0;
      cnt_r   <= '0;
      found_r <= 1'b0;
      hout_r  <= '0;
      stat_r  <= lphi_pkg::STAT_OK;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      hout_r  <= hout_nxt;
      stat_r  <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    if (accept) begin
      func_r <= in_func;
      hash_r <= in_key_hash;
      key_r  <= in_key_word;
      eh_r   <= in_entry_handle;
    end
  end

  // Reset's clearing pass also lands in ST_DONE; suppress its result.
  logic boot_r;
  always_ff @(posedge clk) begin
    if (!rst_n) boot_r <= 1'b1;
    else if (accept) boot_r <= 1'b0;
  end

  wire in_done = (state_r == lphi_pkg::ST_DONE);
  assign in_stall       = (state_r != lphi_pkg::ST_IDLE);
  assign out_valid      = in_done && !boot_r;
  assign out_found      = found_r;
  assign out_handle_out = hout_r;
  assign out_status     = stat_r;
  assign out_occupied   = cnt_r;

endmodule
`default_nettype wire

FILE: tb/lphi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphi_checker: result predictor and comparator for the hash index
// Mirrors the slot table, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module lphi_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_key_hash,
  input  logic [63:0] in_key_word,
  input  logic [15:0] in_entry_handle,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_found,
  input  logic [15:0] out_handle_out,
  input  logic [1:0]  out_status,
  input  logic [10:0] out_occupied,
  output int          fail_count,
  output int          pending_count
);

  localparam int IW = lphi_pkg::IDX_W;
  localparam int QD = 16;

  typedef struct packed {
    logic        found;
    logic [15:0] handle;
    logic [1:0]  status;
    logic [10:0] occupied;
  } lookup_result_t;

  logic [63:0] tbl_hash [lphi_pkg::SLOTS];
  logic [63:0] tbl_key [lphi_pkg::SLOTS];
  logic [15:0] tbl_handle [lphi_pkg::SLOTS];
  logic [10:0] tbl_used;

  // Predicted words wait here until the block delivers its result.
  lookup_result_t result_fifo [QD];
  logic [3:0]     wr_ptr;
  logic [3:0]     rd_ptr;
  int             pending;

  function automatic logic [IW-1:0] wrap_next(logic [IW-1:0] i);
    return i + IW'(1);
  endfunction

  function automatic lookup_result_t apply_word(lphi_pkg::func_t f, logic [63:0] h,
                                                logic [63:0] k, logic [15:0] e);
    lookup_result_t r;
    logic [IW-1:0] i, j, hm;
    bit stays, hit, placed;
    r = '0;
    i = h[IW-1:0];
    case (f)
      lphi_pkg::FUNC_FIND: begin
        for (int n = 0; n < lphi_pkg::SLOTS; n++) begin
          if (tbl_handle[i] == 0) break;
          if (tbl_hash[i] == h && tbl_key[i] == k) begin
            r.handle = tbl_handle[i];
            break;
          end
          i = wrap_next(i);
        end
        r.found = (r.handle != 0);
      end
      lphi_pkg::FUNC_INSERT: begin
        if (e != 0) begin
          if ((int'(tbl_used) + 1) * lphi_pkg::LOAD_DEN >
              lphi_pkg::SLOTS * lphi_pkg::LOAD_NUM) begin
            r.status = lphi_pkg::STAT_FULL;
          end else begin
            placed = 0;
            for (int n = 0; n < lphi_pkg::SLOTS; n++) begin
              if (tbl_handle[i] == 0) begin
                tbl_hash[i] = h;
                tbl_key[i] = k;
                tbl_handle[i] = e;
                tbl_used++;
                placed = 1;
                break;
              end
              i = wrap_next(i);
            end
            if (!placed) r.status = lphi_pkg::STAT_FULL;
          end
        end
      end
      lphi_pkg::FUNC_ERASE: begin
        hit = 0;
        if (e != 0) begin
          for (int n = 0; n < lphi_pkg::SLOTS; n++) begin
            if (tbl_handle[i] == e) begin
              hit = 1;
              break;
            end
            if (tbl_handle[i] == 0) break;
            i = wrap_next(i);
          end
        end
        if (hit) begin
          // Backward shift: pull later cluster members into the hole.
          j = wrap_next(i);
          for (int n = 0; n < lphi_pkg::SLOTS; n++) begin
            if (tbl_handle[j] == 0) break;
            hm = tbl_hash[j][IW-1:0];
            stays = (i <= j) ? (hm > i && hm <= j) : (hm > i || hm <= j);
            if (!stays) begin
              tbl_hash[i] = tbl_hash[j];
              tbl_key[i] = tbl_key[j];
              tbl_handle[i] = tbl_handle[j];
              i = j;
            end
            j = wrap_next(j);
          end
          tbl_handle[i] = 0;
          if (tbl_used > 0) tbl_used--;
          r.found = 1;
        end else begin
          r.status = lphi_pkg::STAT_ABSENT;
        end
      end
      default: begin
        tbl_handle = '{default: '0};
        tbl_used = '0;
      end
    endcase
    r.occupied = tbl_used;
    return r;
  endfunction

  assign pending_count = pending;

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      tbl_handle = '{default: '0};
      tbl_used = '0;
      wr_ptr = '0;
      rd_ptr = '0;
      pending = 0;
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        result_fifo[wr_ptr] = apply_word(lphi_pkg::func_t'(in_func), in_key_hash,
                                         in_key_word, in_entry_handle);
        wr_ptr = wr_ptr + 4'd1;
        pending = pending + 1;
      end
      if (out_valid && !out_stall) begin
        if (pending == 0) begin
          $error("unexpected result word");
          fail_count <= fail_count + 1;
        end else begin
          want = result_fifo[rd_ptr];
          rd_ptr = rd_ptr + 4'd1;
          pending = pending - 1;
          if (want.found !== out_found ||
              want.handle !== out_handle_out ||
              want.status !== out_status ||
              want.occupied !== out_occupied)
            fail_count <= fail_count + 1;
          if (want.found !== out_found)
            $error("found: expected %0d actual %0d", want.found, out_found);
          if (want.handle !== out_handle_out)
            $error("handle_out: expected %0d actual %0d", want.handle, out_handle_out);
          if (want.status !== out_status)
            $error("status: expected %0d actual %0d", want.status, out_status);
          if (want.occupied !== out_occupied)
            $error("occupied: expected %0d actual %0d", want.occupied, out_occupied);
        end
      end
    end
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the linear-probe hash index
// Drives find, insert, erase and clear words, with random idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int IW = lphi_pkg::IDX_W;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [63:0] in_key_hash;
  logic [63:0] in_key_word;
  logic [15:0] in_entry_handle;
  logic        out_valid;
  logic        out_stall;
  logic        out_found;
  logic [15:0] out_handle_out;
  logic [1:0]  out_status;
  logic [10:0] out_occupied;
  int          fail_count;
  int          pending_count;
  int          cycle_count;

  // Random idling is switched off for the closing part of the run, and the
  // long hold-off request comes from the stimulus process.
  bit          idle_enable;
  bit          hold_request;

  // Keys that are live in the table, so that most finds and erases hit.
  logic [63:0] live_hash [$];
  logic [63:0] live_key [$];
  logic [15:0] live_handle [$];
  logic [15:0] next_handle;

  linear_probe_hash_index uut (.*);

  lphi_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 20000000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // The receiver stalls in random bursts. On request it holds off for a long
  // stretch, so the block holds its result and stalls its own input.
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1;
        repeat (60) @(posedge clk);
        out_stall <= 0;
        hold_request = 0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  // Offers one word and waits until it is accepted; an idle burst may come
  // first. Valid stays high while the word is stalled.
  task automatic send_word(lphi_pkg::func_t f, logic [63:0] h, logic [63:0] k,
                           logic [15:0] e);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_key_hash <= h;
    in_key_word <= k;
    in_entry_handle <= e;
    do @(posedge clk); while (in_stall);
  endtask

  // A hash whose home slot is near a given slot, so clusters and wrap-around
  // around the end of the table are common.
  function automatic logic [63:0] near_hash(int unsigned base);
    logic [63:0] h;
    h = {$urandom, $urandom};
    h[IW-1:0] = IW'((base + $urandom_range(0, 7)) % lphi_pkg::SLOTS);
    return h;
  endfunction

  task automatic insert_live(logic [63:0] h, logic [63:0] k);
    next_handle = (next_handle == 16'hFFFF) ? 16'd1 : next_handle + 16'd1;
    send_word(lphi_pkg::FUNC_INSERT, h, k, next_handle);
    live_hash = {live_hash, h};
    live_key = {live_key, k};
    live_handle = {live_handle, next_handle};
  endtask

  task automatic random_word();
    int unsigned pick, idx;
    logic [63:0] h;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      h = ($urandom_range(0, 1) == 0) ? near_hash(lphi_pkg::SLOTS - 4) :
                                        near_hash($urandom_range(0, lphi_pkg::SLOTS - 1));
      insert_live(h, {$urandom, $urandom});
    end else if (pick < 65 && live_hash.size() > 0) begin
      idx = $urandom_range(0, live_hash.size() - 1);
      send_word(lphi_pkg::FUNC_FIND, live_hash[idx], live_key[idx], 16'($urandom));
    end else if (pick < 85 && live_hash.size() > 0) begin
      idx = $urandom_range(0, live_hash.size() - 1);
      send_word(lphi_pkg::FUNC_ERASE, live_hash[idx], 64'($urandom), live_handle[idx]);
      live_hash.delete(idx);
      live_key.delete(idx);
      live_handle.delete(idx);
    end else if (pick < 98) begin
      // Noise: misses, stray handles and zero handles.
      send_word(lphi_pkg::func_t'($urandom_range(0, 2)), {$urandom, $urandom},
                {$urandom, $urandom}, $urandom_range(0, 1) ? 16'd0 : 16'($urandom));
    end else begin
      send_word(lphi_pkg::FUNC_CLEAR, {$urandom, $urandom}, {$urandom, $urandom},
                16'($urandom));
      live_hash.delete();
      live_key.delete();
      live_handle.delete();
    end
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    in_func = lphi_pkg::FUNC_FIND;
    in_key_hash = '0;
    in_key_word = '0;
    in_entry_handle = '0;
    idle_enable = 1;
    hold_request = 0;
    next_handle = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;

    // Directed part: field extremes, every operation and the special cases.
    send_word(lphi_pkg::FUNC_FIND, '0, '0, '0);
    send_word(lphi_pkg::FUNC_INSERT, '1, '1, 16'hFFFF);
    send_word(lphi_pkg::FUNC_FIND, '1, '1, '0);
    send_word(lphi_pkg::FUNC_FIND, '1, '0, '0);
    send_word(lphi_pkg::FUNC_INSERT, 64'h3FF, 64'h5, 16'd0);
    send_word(lphi_pkg::FUNC_INSERT, 64'h3FF, 64'h5, 16'h0001);
    send_word(lphi_pkg::FUNC_INSERT, 64'h3FF, 64'h5, 16'h0002);
    send_word(lphi_pkg::FUNC_INSERT, 64'h0, 64'h6, 16'h0003);
    send_word(lphi_pkg::FUNC_FIND, 64'h3FF, 64'h5, '0);
    send_word(lphi_pkg::FUNC_ERASE, 64'h3FF, '0, 16'hFFFF);
    send_word(lphi_pkg::FUNC_FIND, 64'h0, 64'h6, '0);
    send_word(lphi_pkg::FUNC_ERASE, 64'h3FF, '0, 16'h0000);
    send_word(lphi_pkg::FUNC_ERASE, 64'h123, '0, 16'h7777);
    send_word(lphi_pkg::FUNC_ERASE, 64'h3FF, '0, 16'h0001);
    send_word(lphi_pkg::FUNC_FIND, 64'h3FF, 64'h5, '0);
    send_word(lphi_pkg::FUNC_FIND, 64'h0, 64'h6, '0);
    send_word(lphi_pkg::FUNC_CLEAR, '1, '1, 16'hFFFF);
    send_word(lphi_pkg::FUNC_FIND, 64'h0, 64'h6, '0);

    // Fill to the load limit, then two more inserts are refused.
    next_handle = 16'hFFF0;
    for (int n = 0; n < lphi_pkg::LOAD_LIMIT + 2; n++)
      insert_live(near_hash($urandom_range(0, lphi_pkg::SLOTS - 1)), {$urandom, $urandom});
    for (int n = 0; n < 40; n++) random_word();
    send_word(lphi_pkg::FUNC_CLEAR, '0, '0, '0);
    live_hash.delete();
    live_key.delete();
    live_handle.delete();

    // Random part; the long hold-off falls early, idling stops near the end.
    for (int n = 0; n < 220; n++) begin
      if (n == 50) hold_request = 1;
      if (n == 180) idle_enable = 0;
      random_word();
    end
    in_valid <= 0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (2 * lphi_pkg::SLOTS + 50) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/lphi_pkg.sv
hdl/linear_probe_hash_index.sv
tb/lphi_checker.sv
tb/testbench.sv
